### rtl/core/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and tables of the UTF-8 decoder
// Byte class table, automaton transition table, result item layout and the
// codes used by more than one file.
// ----------------------------------------------------------------------------
package u8d_pkg;

  // Field widths of a result item.
  localparam int CP_W        = 21;
  localparam int OFF_FIELD_W = 16;

  // Automaton state codes.
  localparam logic [3:0] ST_ACCEPT  = 4'd0;
  localparam logic [3:0] ST_REJECT  = 4'd1;
  localparam logic [3:0] NUM_STATES = 4'd9;

  // Result item kinds.
  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  // Byte classes.
  localparam logic [3:0] CLS_ASCII    = 4'd0;   // 00..7F
  localparam logic [3:0] CLS_CONT_LO  = 4'd1;   // 80..8F
  localparam logic [3:0] CLS_LEAD2    = 4'd2;   // C2..DF
  localparam logic [3:0] CLS_LEAD3    = 4'd3;   // E1..EC, EE..EF
  localparam logic [3:0] CLS_ED       = 4'd4;   // ED
  localparam logic [3:0] CLS_F4       = 4'd5;   // F4
  localparam logic [3:0] CLS_LEAD4    = 4'd6;   // F1..F3
  localparam logic [3:0] CLS_CONT_HI  = 4'd7;   // A0..BF
  localparam logic [3:0] CLS_INVALID  = 4'd8;   // C0, C1, F5..FF
  localparam logic [3:0] CLS_CONT_MID = 4'd9;   // 90..9F
  localparam logic [3:0] CLS_E0       = 4'd10;  // E0
  localparam logic [3:0] CLS_F0       = 4'd11;  // F0

  // Next state, indexed by current state and byte class.
  localparam logic [3:0] NEXT_TBL [0:8][0:15] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
      4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
      4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Automaton state and the code point being assembled.
  typedef struct packed {
    logic [3:0]      dfa;
    logic [CP_W-1:0] acc;
  } u8d_dfa_t;

  // One result item.
  typedef struct packed {
    logic                   kind;
    logic [CP_W-1:0]        cp;
    logic [1:0]             units;
    logic [OFF_FIELD_W-1:0] off;
    logic                   last;
  } u8d_result_t;

  // Maps a raw byte to its class.
  function automatic logic [3:0] u8d_byte_class(input logic [7:0] b);
    logic [3:0] cls;
    if (b < 8'h80) begin
      cls = CLS_ASCII;
    end else if (b < 8'h90) begin
      cls = CLS_CONT_LO;
    end else if (b < 8'hA0) begin
      cls = CLS_CONT_MID;
    end else if (b < 8'hC0) begin
      cls = CLS_CONT_HI;
    end else if (b < 8'hC2) begin
      cls = CLS_INVALID;
    end else if (b < 8'hE0) begin
      cls = CLS_LEAD2;
    end else if (b == 8'hE0) begin
      cls = CLS_E0;
    end else if (b == 8'hED) begin
      cls = CLS_ED;
    end else if (b < 8'hF0) begin
      cls = CLS_LEAD3;
    end else if (b == 8'hF0) begin
      cls = CLS_F0;
    end else if (b < 8'hF4) begin
      cls = CLS_LEAD4;
    end else if (b == 8'hF4) begin
      cls = CLS_F4;
    end else begin
      cls = CLS_INVALID;
    end
    return cls;
  endfunction

  // True for the reject state and for any unused state code.
  function automatic logic u8d_is_reject(input logic [3:0] st);
    return (st == ST_REJECT) || (st >= NUM_STATES);
  endfunction

endpackage

### rtl/core/u8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_step: one byte through the UTF-8 automaton
// Classifies the byte, steps the automaton, replays a breaking byte once
// from the accept state, and forms the results caused by the byte.
// ----------------------------------------------------------------------------
module u8d_step import u8d_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic [7:0]             data_byte_i,
  input  logic                   end_of_text_i,
  input  u8d_dfa_t               dfa_i,
  input  logic [OFFSET_BITS-1:0] byte_cnt_i,
  input  logic [OFFSET_BITS-1:0] char_start_i,
  output u8d_dfa_t               dfa_o,
  output logic [OFFSET_BITS-1:0] byte_cnt_o,
  output logic [OFFSET_BITS-1:0] char_start_o,
  output logic [1:0]             res_cnt_o,
  output u8d_result_t            res0_o,
  output u8d_result_t            res1_o
);

  // Low bits of an offset, zero-extended where the counter is narrower.
  function automatic logic [OFF_FIELD_W-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+OFF_FIELD_W-1:0] ext;
    ext = {{OFF_FIELD_W{1'b0}}, v};
    return ext[OFF_FIELD_W-1:0];
  endfunction

  logic [3:0]             cls;
  logic [3:0]             st1;
  logic [3:0]             ns1;
  logic [3:0]             ns2;
  logic [CP_W-1:0]        acc1;
  logic [CP_W-1:0]        acc2;
  logic                   emit;
  logic [CP_W-1:0]        emit_cp;
  logic [OFFSET_BITS-1:0] byte_next;
  u8d_result_t            char_res;
  u8d_result_t            end_res;

  // First pass from the current state, and the replay pass from accept.
  always_comb begin
    cls  = u8d_byte_class(data_byte_i);
    st1  = (dfa_i.dfa < NUM_STATES) ? dfa_i.dfa : ST_REJECT;
    acc2 = CP_W'((8'hFF >> cls) & data_byte_i);
    if (st1 != ST_ACCEPT) begin
      acc1 = {dfa_i.acc[CP_W-7:0], data_byte_i[5:0]};
    end else begin
      acc1 = acc2;
    end
    ns1 = NEXT_TBL[st1][cls];
    ns2 = NEXT_TBL[ST_ACCEPT][cls];
  end

  // Pick the outcome: completion, rejection with replay, or partial sequence.
  always_comb begin
    dfa_o.dfa = ns1;
    dfa_o.acc = acc1;
    emit      = 1'b0;
    emit_cp   = acc1;
    if (ns1 == ST_ACCEPT) begin
      emit = 1'b1;
    end else if (u8d_is_reject(ns1)) begin
      dfa_o.dfa = ST_ACCEPT;
      if (dfa_i.dfa != ST_ACCEPT) begin
        dfa_o.acc = acc2;
        if (ns2 == ST_ACCEPT) begin
          emit    = 1'b1;
          emit_cp = acc2;
        end else if (!u8d_is_reject(ns2)) begin
          dfa_o.dfa = ns2;
        end
      end
    end

    // Saturating byte counter; a completed character moves the start mark.
    byte_next    = (byte_cnt_i == {OFFSET_BITS{1'b1}}) ? byte_cnt_i
                                                       : byte_cnt_i + 1'b1;
    byte_cnt_o   = byte_next;
    char_start_o = emit ? byte_next : char_start_i;

    // End of text returns everything to its reset values.
    if (end_of_text_i) begin
      dfa_o.dfa    = ST_ACCEPT;
      dfa_o.acc    = '0;
      byte_cnt_o   = '0;
      char_start_o = '0;
    end
  end

  // Result items.
  always_comb begin
    char_res.kind  = ITEM_CHAR;
    char_res.cp    = emit_cp;
    char_res.units = (emit_cp >= CP_W'(32'h10000)) ? 2'd2 : 2'd1;
    char_res.off   = to_field(char_start_i);
    char_res.last  = !end_of_text_i;

    end_res.kind  = ITEM_END;
    end_res.cp    = '0;
    end_res.units = 2'd0;
    end_res.off   = to_field(byte_next);
    end_res.last  = 1'b1;

    res_cnt_o = {1'b0, emit} + {1'b0, end_of_text_i};
    res0_o    = emit ? char_res : end_res;
    res1_o    = end_res;
  end

endmodule

### rtl/core/u8d_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_result_fifo: result item queue
// Four-entry queue that takes up to two items per cycle and hands out one.
// ----------------------------------------------------------------------------
module u8d_result_fifo import u8d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  wr_cnt_i,
  input  u8d_result_t wr0_i,
  input  u8d_result_t wr1_i,
  input  logic        pop_i,
  output logic        room2_o,
  output logic        nonempty_o,
  output logic [2:0]  count_o,
  output u8d_result_t head_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  u8d_result_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] wp_plus1;

  // Pointer and fill count updates.
  always_comb begin
    wp_plus1 = wp_q + 1'b1;
    wp_d     = wp_q + PTR_W'(wr_cnt_i);
    rp_d     = rp_q + PTR_W'(pop_i);
    cnt_d    = cnt_q + CNT_W'(wr_cnt_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage; the first item goes to the write pointer, the second after it.
  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem_q[wp_q] <= wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem_q[wp_plus1] <= wr1_i;
    end
  end

  assign room2_o    = cnt_q <= CNT_W'(DEPTH - 2);
  assign nonempty_o = cnt_q != '0;
  assign count_o    = cnt_q;
  assign head_o     = mem_q[rp_q];

endmodule

### rtl/core/utf8_decoder_with_offsets.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_offsets: streaming UTF-8 decoder with byte offsets
// Decodes a byte stream into code points with their UTF-16 length and start
// offset, and closes each text with an end marker carrying its length.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle while the input is not stalled.
// Each byte is classified, stepped through the validation automaton and, when
// it breaks a partial sequence, replayed once from the accept state, all in the
// same cycle; its results are registered in a four-entry result queue that
// feeds the output. A byte gives zero, one or two items (a completed character
// and, on the last byte of a text, the end marker), and the output delivers one
// item per cycle while out_stall_i is low, so a final byte that completes a
// character gives two output items. The input stalls whenever the queue has
// fewer than two free entries. Invalid sequences yield no item. Offsets count in
// OFFSET_BITS-bit saturating counters and are reported in 16 bits.
module utf8_decoder_with_offsets import u8d_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [20:0] code_point_o,
  output logic [1:0]  utf16_units_o,
  output logic [15:0] byte_offset_o,
  output logic        last_of_run_o
);

  u8d_dfa_t               dfa_q, dfa_d;
  logic [OFFSET_BITS-1:0] byte_cnt_q, byte_cnt_d;
  logic [OFFSET_BITS-1:0] char_start_q, char_start_d;
  logic [1:0]             res_cnt;
  u8d_result_t            res0;
  u8d_result_t            res1;
  u8d_result_t            head;
  logic                   room2;
  logic                   nonempty;
  logic [2:0]             fifo_cnt;
  logic                   in_accept;
  logic                   out_accept;

  assign in_stall_o = !room2;
  assign in_accept  = in_valid_i && room2;
  assign out_accept = nonempty && !out_stall_i;

  // Per-byte decode step.
  u8d_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .dfa_i         (dfa_q),
    .byte_cnt_i    (byte_cnt_q),
    .char_start_i  (char_start_q),
    .dfa_o         (dfa_d),
    .byte_cnt_o    (byte_cnt_d),
    .char_start_o  (char_start_d),
    .res_cnt_o     (res_cnt),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  // Decoder state, updated on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfa_q        <= '0;
      byte_cnt_q   <= '0;
      char_start_q <= '0;
    end else if (in_accept) begin
      dfa_q        <= dfa_d;
      byte_cnt_q   <= byte_cnt_d;
      char_start_q <= char_start_d;
    end
  end

  // Result queue between the decoder and the output channel.
  u8d_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (in_accept ? res_cnt : 2'd0),
    .wr0_i      (res0),
    .wr1_i      (res1),
    .pop_i      (out_accept),
    .room2_o    (room2),
    .nonempty_o (nonempty),
    .count_o    (fifo_cnt),
    .head_o     (head)
  );

  assign out_valid_o   = nonempty;
  assign item_kind_o   = head.kind;
  assign code_point_o  = head.cp;
  assign utf16_units_o = head.units;
  assign byte_offset_o = head.off;
  assign last_of_run_o = head.last;

  // The queue never holds more than its four entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_cnt <= 3'd4)
    else $error("result queue overflow");

  // The automaton never rests in the reject state or an unused code.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !u8d_is_reject(dfa_q.dfa))
    else $error("automaton left in reject or unused state");

  // The last byte of a text returns the decoder to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && end_of_text_i |=>
      dfa_q.dfa == ST_ACCEPT && byte_cnt_q == '0 && char_start_q == '0)
    else $error("decoder state not cleared after end of text");

  // A delivered end marker is always the last item of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_accept && item_kind_o == ITEM_END |-> last_of_run_o)
    else $error("end marker not marked last");

endmodule
